>>> hdl/lfs_pkg.sv
package lfs_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int TOTAL_WIDTH       = 64;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHK,
        S_DIVA_GO,
        S_DIVA_WAIT,
        S_TRI_GO,
        S_TRI_WAIT,
        S_TQ_GO,
        S_TQ_WAIT,
        S_DIVB_GO,
        S_DIVB_WAIT,
        S_NB_GO,
        S_NB_WAIT,
        S_Y_GO,
        S_Y_WAIT,
        S_YCMP,
        S_DIVY_GO,
        S_DIVY_WAIT,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_A,
        OP_DIV_B,
        OP_DIV_Y,
        OP_MUL_TRI,
        OP_MUL_TQ,
        OP_MUL_NB,
        OP_MUL_Y,
        OP_WB_A,
        OP_WB_TRI,
        OP_WB_ACC,
        OP_WB_B,
        OP_WB_Y,
        OP_WB_DIVY
    } op_t;

    typedef struct packed {
        logic m_zero;
        logic a_ge_m;
        logic b_ge_m;
        logic y_lt_m;
        logic div_done;
        logic mul_done;
    } status_t;

endpackage

>>> hdl/lfs_div.sv
module lfs_div #(
    parameter int W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [2*W-1:0] dividend,
    input  logic [W-1:0]   divisor,
    output logic [W-1:0]   quotient,
    output logic [W-1:0]   remainder,
    output logic           done
);
    localparam int DW   = 2 * W;
    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]   dvd_reg, dvd_next;
    logic [W-1:0]    rem_reg, rem_next;
    logic [W-1:0]    dsr_reg, dsr_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            done_reg, done_next;
    logic [W:0]      trial;
    logic            fits;

    assign trial = {rem_reg, dvd_reg[DW-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = CNTW'(DW);
        end
        else if (cnt_reg != '0)
        begin
            // shift one dividend bit into the remainder, quotient bit into the low end
            rem_next  = fits ? W'(trial - {1'b0, dsr_reg}) : trial[W-1:0];
            dvd_next  = {dvd_reg[DW-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNTW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = dvd_reg[W-1:0];
    assign remainder = rem_reg;
    assign done      = done_reg;
endmodule

>>> hdl/lfs_mul.sv
module lfs_mul #(
    parameter int W = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [lfs_pkg::TOTAL_WIDTH-1:0] mcand,
    input  logic [W-1:0]                    mplier,
    output logic [lfs_pkg::TOTAL_WIDTH-1:0] prod,
    output logic                            done
);
    import lfs_pkg::*;

    localparam int CNTW = $clog2(W + 1);

    logic [TOTAL_WIDTH-1:0] mcand_reg, mcand_next;
    logic [TOTAL_WIDTH-1:0] prod_reg, prod_next;
    logic [W-1:0]           mplier_reg, mplier_next;
    logic [CNTW-1:0]        cnt_reg, cnt_next;
    logic                   done_reg, done_next;

    always_comb
    begin
        mcand_next  = mcand_reg;
        prod_next   = prod_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        if (start)
        begin
            mcand_next  = mcand;
            mplier_next = mplier;
            prod_next   = '0;
            cnt_next    = CNTW'(W);
        end
        else if (cnt_reg != '0)
        begin
            // product keeps only the low word, which is all the total needs
            if (mplier_reg[0])
                prod_next = prod_reg + mcand_reg;
            mcand_next  = {mcand_reg[TOTAL_WIDTH-2:0], 1'b0};
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 1'b1;
            done_next   = (cnt_reg == CNTW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        prod_reg   <= prod_next;
        mplier_reg <= mplier_next;
    end

    assign prod = prod_reg;
    assign done = done_reg;
endmodule

>>> hdl/lfs_dpath.sv
module lfs_dpath #(
    parameter int W = lfs_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lfs_pkg::op_t                    op,
    input  logic [W-1:0]                    count_n,
    input  logic [W-1:0]                    divisor_m,
    input  logic [W-1:0]                    slope_a,
    input  logic [W-1:0]                    offset_b,
    output lfs_pkg::status_t                status,
    output logic [lfs_pkg::TOTAL_WIDTH-1:0] total,
    output logic                            bad_divisor
);
    import lfs_pkg::*;

    localparam int DW = 2 * W;

    logic [W-1:0]           n_reg, n_next, m_reg, m_next, a_reg, a_next, b_reg, b_next;
    logic [TOTAL_WIDTH-1:0] acc_reg, acc_next, tri_reg, tri_next;
    logic [DW-1:0]          y_reg, y_next;

    logic                   div_start, mul_start, div_done, mul_done;
    logic [DW-1:0]          div_dividend;
    logic [W-1:0]           quot, rem;
    logic [TOTAL_WIDTH-1:0] mul_mcand, prod;
    logic [W-1:0]           mul_mplier;

    assign div_start = (op == OP_DIV_A) || (op == OP_DIV_B) || (op == OP_DIV_Y);
    assign mul_start = (op == OP_MUL_TRI) || (op == OP_MUL_TQ) || (op == OP_MUL_NB)
                    || (op == OP_MUL_Y);

    always_comb
    begin
        case (op)
            OP_DIV_A: div_dividend = DW'(a_reg);
            OP_DIV_B: div_dividend = DW'(b_reg);
            default:  div_dividend = y_reg;
        endcase
    end

    always_comb
    begin
        case (op)
            OP_MUL_TRI:
            begin
                mul_mcand  = TOTAL_WIDTH'(n_reg);
                mul_mplier = n_reg - 1'b1;
            end
            OP_MUL_TQ:
            begin
                mul_mcand  = tri_reg;
                mul_mplier = quot;
            end
            OP_MUL_NB:
            begin
                mul_mcand  = TOTAL_WIDTH'(n_reg);
                mul_mplier = quot;
            end
            default:
            begin
                mul_mcand  = TOTAL_WIDTH'(a_reg);
                mul_mplier = n_reg;
            end
        endcase
    end

    lfs_div #(.W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (m_reg),
        .quotient  (quot),
        .remainder (rem),
        .done      (div_done)
    );

    lfs_mul #(.W(W)) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mcand  (mul_mcand),
        .mplier (mul_mplier),
        .prod   (prod),
        .done   (mul_done)
    );

    always_comb
    begin
        n_next   = n_reg;
        m_next   = m_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        acc_next = acc_reg;
        tri_next = tri_reg;
        y_next   = y_reg;
        case (op)
            OP_LOAD:
            begin
                n_next   = count_n;
                m_next   = divisor_m;
                a_next   = slope_a;
                b_next   = offset_b;
                acc_next = '0;
            end
            OP_WB_A:   a_next   = rem;
            OP_WB_TRI: tri_next = prod >> 1;
            OP_WB_ACC: acc_next = acc_reg + prod;
            OP_WB_B:   b_next   = rem;
            OP_WB_Y:   y_next   = prod[DW-1:0] + DW'(b_reg);
            OP_WB_DIVY:
            begin
                // continue with (y/m, a, m, y%m): divisor and slope trade places
                n_next = quot;
                b_next = rem;
                a_next = m_reg;
                m_next = a_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        m_reg   <= m_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        tri_reg <= tri_next;
        y_reg   <= y_next;
    end

    assign status.m_zero   = (m_reg == '0);
    assign status.a_ge_m   = (a_reg >= m_reg);
    assign status.b_ge_m   = (b_reg >= m_reg);
    assign status.y_lt_m   = (y_reg < DW'(m_reg));
    assign status.div_done = div_done;
    assign status.mul_done = mul_done;

    assign total       = acc_reg;
    assign bad_divisor = (m_reg == '0);
endmodule

>>> hdl/lfs_ctrl.sv
module lfs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  lfs_pkg::status_t status,
    output lfs_pkg::op_t     op,
    output logic             busy,
    output logic             done
);
    import lfs_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (start) state_next = S_CHK;
            S_CHK:       state_next = status.m_zero ? S_DONE : S_DIVA_GO;
            S_DIVA_GO:   state_next = status.a_ge_m ? S_DIVA_WAIT : S_DIVB_GO;
            S_DIVA_WAIT: if (status.div_done) state_next = S_TRI_GO;
            S_TRI_GO:    state_next = S_TRI_WAIT;
            S_TRI_WAIT:  if (status.mul_done) state_next = S_TQ_GO;
            S_TQ_GO:     state_next = S_TQ_WAIT;
            S_TQ_WAIT:   if (status.mul_done) state_next = S_DIVB_GO;
            S_DIVB_GO:   state_next = status.b_ge_m ? S_DIVB_WAIT : S_Y_GO;
            S_DIVB_WAIT: if (status.div_done) state_next = S_NB_GO;
            S_NB_GO:     state_next = S_NB_WAIT;
            S_NB_WAIT:   if (status.mul_done) state_next = S_Y_GO;
            S_Y_GO:      state_next = S_Y_WAIT;
            S_Y_WAIT:    if (status.mul_done) state_next = S_YCMP;
            S_YCMP:      state_next = status.y_lt_m ? S_DONE : S_DIVY_GO;
            S_DIVY_GO:   state_next = S_DIVY_WAIT;
            S_DIVY_WAIT: if (status.div_done) state_next = S_DIVA_GO;
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op   = OP_NONE;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start) op = OP_LOAD;
            end
            S_DIVA_GO:   if (status.a_ge_m) op = OP_DIV_A;
            S_DIVA_WAIT: if (status.div_done) op = OP_WB_A;
            S_TRI_GO:    op = OP_MUL_TRI;
            S_TRI_WAIT:  if (status.mul_done) op = OP_WB_TRI;
            S_TQ_GO:     op = OP_MUL_TQ;
            S_TQ_WAIT:   if (status.mul_done) op = OP_WB_ACC;
            S_DIVB_GO:   if (status.b_ge_m) op = OP_DIV_B;
            S_DIVB_WAIT: if (status.div_done) op = OP_WB_B;
            S_NB_GO:     op = OP_MUL_NB;
            S_NB_WAIT:   if (status.mul_done) op = OP_WB_ACC;
            S_Y_GO:      op = OP_MUL_Y;
            S_Y_WAIT:    if (status.mul_done) op = OP_WB_Y;
            S_DIVY_GO:   op = OP_DIV_Y;
            S_DIVY_WAIT: if (status.div_done) op = OP_WB_DIVY;
            S_DONE:      done = 1'b1;
            default:     op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

>>> hdl/linear_floor_sum_top.sv
// Floor sum: total = sum over i in [0, count_n) of floor((slope_a*i + offset_b) / divisor_m),
// modulo 2^64, by the Euclidean reduction.
// Input: raise start with count_n, divisor_m, slope_a, offset_b; the item is taken at
// the edge where start is high and busy is low. busy stays high until the result.
// Output: done is high for exactly one cycle with total and bad_divisor valid; the
// receiver must take it then, there is no back-pressure.
// A zero divisor_m gives bad_divisor = 1 and total = 0, with no division run.
// Each reduction round runs up to three divisions on one shared restoring divider
// and four multiplies on one shared shift-add multiplier, with control states
// between them. The round count grows with log(divisor_m), at most about 46 for
// OPERAND_WIDTH = 32. One item at a time.
// Reset clears the controller to idle; no result is pending after reset.
module linear_floor_sum_top #(
    parameter int OPERAND_WIDTH = lfs_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [OPERAND_WIDTH-1:0]        count_n,
    input  logic [OPERAND_WIDTH-1:0]        divisor_m,
    input  logic [OPERAND_WIDTH-1:0]        slope_a,
    input  logic [OPERAND_WIDTH-1:0]        offset_b,
    output logic                            done,
    output logic [lfs_pkg::TOTAL_WIDTH-1:0] total,
    output logic                            bad_divisor
);
    import lfs_pkg::*;

    op_t     op;
    status_t status;

    lfs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .op     (op),
        .busy   (busy),
        .done   (done)
    );

    lfs_dpath #(.W(OPERAND_WIDTH)) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .count_n     (count_n),
        .divisor_m   (divisor_m),
        .slope_a     (slope_a),
        .offset_b    (offset_b),
        .status      (status),
        .total       (total),
        .bad_divisor (bad_divisor)
    );

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepting an item");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && bad_divisor |-> total == '0)
        else $error("nonzero total with bad divisor");

    a_idle_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !done)
        else $error("done while idle");
`endif
endmodule

>>> dv/linear_floor_sum_top_tb.sv
module linear_floor_sum_top_tb;

    import lfs_pkg::*;

    localparam int W         = 32;
    localparam int MAX_CYC   = 30000000;

    typedef struct {
        logic [W-1:0] n;
        logic [W-1:0] m;
        logic [W-1:0] a;
        logic [W-1:0] b;
    } sum_item_t;

    typedef struct {
        logic [TOTAL_WIDTH-1:0] total;
        logic                   bad;
    } sum_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [W-1:0]           count_n;
    logic [W-1:0]           divisor_m;
    logic [W-1:0]           slope_a;
    logic [W-1:0]           offset_b;
    logic                   done;
    logic [TOTAL_WIDTH-1:0] total;
    logic                   bad_divisor;

    sum_item_t   pending_items[$];
    sum_result_t expected_sums[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          burst_left;
    int          gap_left;
    bit          drain_hold;

    linear_floor_sum_top #(.OPERAND_WIDTH(W)) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .count_n     (count_n),
        .divisor_m   (divisor_m),
        .slope_a     (slope_a),
        .offset_b    (offset_b),
        .done        (done),
        .total       (total),
        .bad_divisor (bad_divisor)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Euclidean floor sum, 64-bit wrapping accumulator
    function automatic sum_result_t predict_sum(sum_item_t it);
        sum_result_t      r;
        logic [63:0]      n;
        logic [63:0]      m;
        logic [63:0]      a;
        logic [63:0]      b;
        logic [63:0]      y;
        logic [63:0]      tmp;
        logic [63:0]      acc;
        n = it.n;
        m = it.m;
        a = it.a;
        b = it.b;
        acc = '0;
        if (m == 0)
        begin
            r.total = '0;
            r.bad   = 1'b1;
            return r;
        end
        forever
        begin
            if (a >= m)
            begin
                acc = acc + ((n * (n - (n != 0 ? 64'd1 : 64'd0))) / 2) * (a / m);
                a = a % m;
            end
            if (b >= m)
            begin
                acc = acc + n * (b / m);
                b = b % m;
            end
            y = a * n + b;
            if (y < m)
                break;
            n = y / m;
            b = y % m;
            tmp = a;
            a = m;
            m = tmp;
        end
        r.total = acc;
        r.bad   = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        fail_count++;
    endtask

    function automatic logic [W-1:0] rand_operand();
        case ($urandom_range(0, 5))
            0: rand_operand = $urandom_range(0, 3);
            1: rand_operand = $urandom_range(0, 100);
            2: rand_operand = $urandom_range(0, 5000);
            3: rand_operand = $urandom >> $urandom_range(0, 31);
            4: rand_operand = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: rand_operand = $urandom;
        endcase
    endfunction

    task automatic push_item(logic [W-1:0] n, logic [W-1:0] m, logic [W-1:0] a,
                             logic [W-1:0] b);
        sum_item_t it;
        it.n = n;
        it.m = m;
        it.a = a;
        it.b = b;
        pending_items.push_back(it);
    endtask

    // driver: bursts with random gaps, pauses to drain at a marked point
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            count_n    <= '0;
            divisor_m  <= '0;
            slope_a    <= '0;
            offset_b   <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_sums.push_back(predict_sum('{count_n, divisor_m, slope_a,
                                                      offset_b}));
                void'(pending_items.pop_front());
            end
            if (start && busy)
            begin
                // hold the item until it is taken
            end
            else if (drain_hold && (expected_sums.size() != 0 || (start && !busy)))
                start <= 1'b0;
            else if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_items.size() != 0)
            begin
                sum_item_t it;
                it = pending_items[0];
                start     <= 1'b1;
                count_n   <= it.n;
                divisor_m <= it.m;
                slope_a   <= it.a;
                offset_b  <= it.b;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 6);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (done)
            begin
                if (expected_sums.size() == 0)
                    report_mismatch("unexpected result", total, 0);
                else
                begin
                    sum_result_t e;
                    e = expected_sums.pop_front();
                    if (total !== e.total)
                        report_mismatch("total", total, e.total);
                    if (bad_divisor !== e.bad)
                        report_mismatch("bad_divisor", bad_divisor, e.bad);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count >= MAX_CYC)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int k;
        drain_hold  = 1'b0;
        rst_n       = 1'b0;

        // directed: zero divisor, zero count, extremes, small and large mixes
        push_item(5, 0, 3, 7);
        push_item('1, 0, '1, '1);
        push_item(0, 7, 9, 11);
        push_item(0, 0, 0, 0);
        push_item(1, 1, 0, 0);
        push_item(10, 3, 2, 1);
        push_item(10, 3, 0, 5);
        push_item(4, 10, 6, 3);
        push_item('1, '1, '1, '1);
        push_item('1, 1, '1, '1);
        push_item('1, '1, 0, 0);
        push_item('1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
        push_item(1000, 32'd2971215073, 32'd1836311903, 0);
        push_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        push_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        push_item(100, 7, 100, 1);
        push_item(1, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFE);
        push_item(2, 1, 1, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < 300; k++)
        begin
            if (k == 150)
            begin
                wait (pending_items.size() == 0);
                drain_hold = 1'b1;
                wait (expected_sums.size() == 0 && !start && !busy);
                drain_hold = 1'b0;
            end
            push_item(rand_operand(), ($urandom_range(0, 30) == 0) ? '0 : rand_operand(),
                      rand_operand(), rand_operand());
        end

        wait (pending_items.size() == 0);
        @(posedge clk);
        wait (expected_sums.size() == 0 && !start);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> linear_floor_sum_top.f
hdl/lfs_pkg.sv
hdl/lfs_div.sv
hdl/lfs_mul.sv
hdl/lfs_dpath.sv
hdl/lfs_ctrl.sv
hdl/linear_floor_sum_top.sv
dv/linear_floor_sum_top_tb.sv
